// ===== design/gb9_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gb9_pkg
// Shared constants, register indexes and the Q0.16 mask for the 9x9 blur.
// ----------------------------------------------------------------------------
package gb9_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int LsCols    = MaxWidth + 4;
    localparam int DimW      = 11;
    localparam int ColW      = $clog2(LsCols);
    localparam int CfgIdxW   = 8;
    localparam int RowSumW   = 21;
    localparam int AccW      = 25;

    typedef enum logic [CfgIdxW-1:0] {
        RegImageWidth  = 8'd0,
        RegImageHeight = 8'd1
    } cfg_reg_t;

    // Q0.16 coefficient by row distance and column distance from center
    localparam logic [9:0] GaussQ16 [0:4][0:4] = '{
        '{10'd864, 10'd860, 10'd847, 10'd826, 10'd798},
        '{10'd860, 10'd856, 10'd843, 10'd822, 10'd794},
        '{10'd847, 10'd843, 10'd830, 10'd810, 10'd782},
        '{10'd826, 10'd822, 10'd810, 10'd790, 10'd763},
        '{10'd798, 10'd794, 10'd782, 10'd763, 10'd736}
    };

    function automatic logic [2:0] dist4(input logic [3:0] i);
        logic [3:0] d;
        d = (i >= 4'd4) ? (i - 4'd4) : (4'd4 - i);
        return d[2:0];
    endfunction

    function automatic logic [9:0] gauss_coef(input logic [3:0] m, input logic [3:0] n);
        return GaussQ16[dist4(m)][dist4(n)];
    endfunction

    function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] maxv);
        logic [DimW-1:0] r;
        if (v == '0)
            r = DimW'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/gaussian_blur_9x9_rgba.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_9x9_rgba
// 9x9 Gaussian blur over an RGBA8888 raster stream with padding positions.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock over a raster of (height+4) by (width+4)
// positions and returns one blurred pixel per beat once four rows and four
// columns of lookahead have arrived. Four register stages lie between input
// and output (line store read, window, row sums, channel sum), and a result
// passes all four once its last neighbor is accepted, whether or not more
// beats follow; the whole pipeline holds while a result waits on the output.
// Eight line store banks, one per row, are all read at the current column on
// every beat, and the bank of the oldest row is overwritten there. Writing a
// width or height register restarts the frame.
module gaussian_blur_9x9_rgba (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [31:0] pixel_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pixel_out,
    output logic             frame_last
);

    localparam int DimW = gb9_pkg::DimW;
    localparam int ColW = gb9_pkg::ColW;

    logic [DimW-1:0] width_reg, height_reg;
    logic [DimW-1:0] eff_w, eff_h;
    logic [DimW-1:0] col_reg, row_reg, col_next, row_next;
    logic            advance, accept;
    logic [31:0]     pix;

    // stage 1: line store read
    logic            s1_valid_reg;
    logic [31:0]     s1_pix_reg;
    logic [DimW-1:0] s1_row_reg, s1_col_reg;
    logic [31:0]     rd_reg [0:7];
    logic [31:0]     ls_mem [0:7][0:gb9_pkg::LsCols-1];

    // stage 2: window
    logic            s2_valid_reg, s2_last_reg;
    logic [31:0]     win_reg [0:8][0:8];
    logic [8:0]      row_ok_reg, col_ok_reg;
    logic            s1_emit, s1_last;
    logic [8:0]      row_ok_next, col_ok_next;

    // stage 3: row sums
    logic                        s3_valid_reg, s3_last_reg;
    logic [7:0]                  s3_alpha_reg;
    logic [gb9_pkg::RowSumW-1:0] rs_r_reg [0:8];
    logic [gb9_pkg::RowSumW-1:0] rs_g_reg [0:8];
    logic [gb9_pkg::RowSumW-1:0] rs_b_reg [0:8];
    logic [gb9_pkg::RowSumW-1:0] rs_r_next [0:8];
    logic [gb9_pkg::RowSumW-1:0] rs_g_next [0:8];
    logic [gb9_pkg::RowSumW-1:0] rs_b_next [0:8];

    // stage 4: output
    logic                     out_valid_reg, frame_last_reg;
    logic [31:0]              pixel_out_reg;
    logic [gb9_pkg::AccW-1:0] acc_r, acc_g, acc_b;
    logic [7:0]               sat_r, sat_g, sat_b;

    assign cfg_ready = 1'b1;
    assign eff_w     = gb9_pkg::eff_dim(width_reg, DimW'(gb9_pkg::MaxWidth));
    assign eff_h     = gb9_pkg::eff_dim(height_reg, DimW'(gb9_pkg::MaxHeight));
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign accept    = in_valid && advance;
    assign pix       = cmd ? 32'd0 : pixel_in;

    always_comb
    begin
        col_next = col_reg + DimW'(1);
        row_next = row_reg;
        if ({1'b0, col_next} >= {1'b0, eff_w} + 12'd4)
        begin
            col_next = '0;
            row_next = row_reg + DimW'(1);
            if ({1'b0, row_next} >= {1'b0, eff_h} + 12'd4)
                row_next = '0;
        end
    end

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DimW'(gb9_pkg::MaxWidth);
            height_reg <= DimW'(gb9_pkg::MaxHeight);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gb9_pkg::RegImageWidth:
                begin
                    width_reg <= cfg_data;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                gb9_pkg::RegImageHeight:
                begin
                    height_reg <= cfg_data;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: ;
            endcase
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store banks: read all rows at this column, overwrite the oldest
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 8; k++)
                rd_reg[k] <= ls_mem[k][col_reg[ColW-1:0]];
            ls_mem[row_reg[2:0]][col_reg[ColW-1:0]] <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pix;
            s1_row_reg <= row_reg;
            s1_col_reg <= col_reg;
        end
    end

    always_comb
    begin
        logic [11:0] y, x;
        s1_emit = (s1_row_reg >= DimW'(4)) && (s1_col_reg >= DimW'(4));
        s1_last = (s1_row_reg == eff_h + DimW'(3)) && (s1_col_reg == eff_w + DimW'(3));
        for (int m = 0; m < 9; m++)
        begin
            y = {1'b0, s1_row_reg} + 12'(m);
            x = {1'b0, s1_col_reg} + 12'(m);
            row_ok_next[m] = (y >= 12'd8) && ((y - 12'd8) < {1'b0, eff_h});
            col_ok_next[m] = (x >= 12'd8) && ((x - 12'd8) < {1'b0, eff_w});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int m = 0; m < 9; m++)
                for (int n = 0; n < 9; n++)
                    win_reg[m][n] <= '0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit;
            if (s1_valid_reg)
            begin
                for (int m = 0; m < 9; m++)
                begin
                    for (int n = 0; n < 8; n++)
                        win_reg[m][n] <= win_reg[m][n+1];
                end
                for (int k = 0; k < 8; k++)
                    win_reg[k][8] <= rd_reg[3'(s1_row_reg[2:0] + 3'(k))];
                win_reg[8][8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            row_ok_reg  <= row_ok_next;
            col_ok_reg  <= col_ok_next;
            s2_last_reg <= s1_last;
        end
    end

    // per-row weighted sums of each channel
    always_comb
    begin
        logic [9:0] q;
        for (int m = 0; m < 9; m++)
        begin
            rs_r_next[m] = '0;
            rs_g_next[m] = '0;
            rs_b_next[m] = '0;
            for (int n = 0; n < 9; n++)
            begin
                q = gb9_pkg::gauss_coef(4'(m), 4'(n));
                if (row_ok_reg[m] && col_ok_reg[n])
                begin
                    rs_r_next[m] = rs_r_next[m]
                                   + gb9_pkg::RowSumW'(win_reg[m][n][7:0])
                                   * gb9_pkg::RowSumW'(q);
                    rs_g_next[m] = rs_g_next[m]
                                   + gb9_pkg::RowSumW'(win_reg[m][n][15:8])
                                   * gb9_pkg::RowSumW'(q);
                    rs_b_next[m] = rs_b_next[m]
                                   + gb9_pkg::RowSumW'(win_reg[m][n][23:16])
                                   * gb9_pkg::RowSumW'(q);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            rs_r_reg     <= rs_r_next;
            rs_g_reg     <= rs_g_next;
            rs_b_reg     <= rs_b_next;
            s3_alpha_reg <= win_reg[4][4][31:24];
            s3_last_reg  <= s2_last_reg;
        end
    end

    always_comb
    begin
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        for (int m = 0; m < 9; m++)
        begin
            acc_r = acc_r + gb9_pkg::AccW'(rs_r_reg[m]);
            acc_g = acc_g + gb9_pkg::AccW'(rs_g_reg[m]);
            acc_b = acc_b + gb9_pkg::AccW'(rs_b_reg[m]);
        end
        // truncate the fraction, then clamp at full scale
        sat_r = (acc_r[gb9_pkg::AccW-1:16] > 9'd255) ? 8'hff : acc_r[23:16];
        sat_g = (acc_g[gb9_pkg::AccW-1:16] > 9'd255) ? 8'hff : acc_g[23:16];
        sat_b = (acc_b[gb9_pkg::AccW-1:16] > 9'd255) ? 8'hff : acc_b[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg)
        begin
            pixel_out_reg  <= {s3_alpha_reg, sat_b, sat_g, sat_r};
            frame_last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

endmodule
`default_nettype wire
